// File: design/mdb_pkg.sv
// ----------------------------------------------------------------------------
// mdb_pkg
// Shared types and constants for the multi-slot debouncer: field widths,
// register indexes, register defaults and the per-slot flag bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mdb_pkg;

   localparam int MASK_W  = 5;   // width of the slot masks in a beat
   localparam int TOTAL_W = 3;   // width of the lit count
   localparam int COUNT_W = 8;   // frame counter and frame thresholds
   localparam int TIME_W  = 32;  // timestamps and timeout
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_ON  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_OFF = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT    = 2'd2;

   localparam logic [COUNT_W-1:0] DEFAULT_ON      = 8'd3;
   localparam logic [COUNT_W-1:0] DEFAULT_OFF     = 8'd4;
   localparam logic [TIME_W-1:0]  DEFAULT_TIMEOUT = 32'd120000;

   // What one slot reports for the current frame.
   typedef struct packed {
      logic stable_valid;
      logic stable_lit;
      logic changed;
   } slot_flags_type;

   // One result beat.
   typedef struct packed {
      logic [MASK_W-1:0]  stable_valid_bits;
      logic [MASK_W-1:0]  stable_lit_bits;
      logic [MASK_W-1:0]  changed_bits;
      logic [TOTAL_W-1:0] lit_total;
   } result_type;

endpackage

`default_nettype wire

// File: design/mdb_lane.sv
// ----------------------------------------------------------------------------
// mdb_lane
// One slot's debouncer: timeout check against the last detection, then the
// four-phase off / candidate-on / on / candidate-off machine with a
// saturating frame counter. State advances on each accepted input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mdb_lane (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [mdb_pkg::TIME_W-1:0]  now,
   input  wire logic                        detected,
   input  wire logic                        lit_raw,
   input  wire logic [mdb_pkg::COUNT_W-1:0] on_need,
   input  wire logic [mdb_pkg::COUNT_W-1:0] off_need,
   input  wire logic [mdb_pkg::TIME_W-1:0]  timeout,
   output mdb_pkg::slot_flags_type          flags
);
   import mdb_pkg::*;

   localparam logic [1:0] PH_OFF      = 2'd0;
   localparam logic [1:0] PH_CAND_ON  = 2'd1;
   localparam logic [1:0] PH_ON       = 2'd2;
   localparam logic [1:0] PH_CAND_OFF = 2'd3;

   logic [1:0]         phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TIME_W-1:0]  last_seen_ff, last_seen_in;
   logic               seen_ff, seen_in;

   logic [TIME_W-1:0]  elapsed;
   logic               timed_out;
   logic               lit;
   logic [1:0]         prev;
   logic [COUNT_W-1:0] count_base;
   logic [COUNT_W-1:0] count_up;

   assign lit       = detected & lit_raw;
   assign elapsed   = now - last_seen_ff;
   assign timed_out = (phase_ff != PH_OFF) && seen_ff && (elapsed > timeout);
   assign prev       = timed_out ? PH_OFF : phase_ff;
   assign count_base = timed_out ? '0 : count_ff;
   assign count_up   = (count_base == '1) ? count_base : count_base + 1'b1;

   always_comb begin
      phase_in     = prev;
      count_in     = count_base;
      last_seen_in = detected ? now : last_seen_ff;
      seen_in      = seen_ff | detected;
      unique case (prev)
         PH_OFF: begin
            if (lit) begin
               phase_in = PH_CAND_ON;
               count_in = COUNT_W'(1);
            end
         end
         PH_CAND_ON: begin
            if (lit) begin
               count_in = count_up;
               if (count_up >= on_need) phase_in = PH_ON;
            end else begin
               phase_in = PH_OFF;
               count_in = '0;
            end
         end
         PH_ON: begin
            if (!lit) begin
               phase_in = PH_CAND_OFF;
               count_in = COUNT_W'(1);
            end
         end
         PH_CAND_OFF: begin
            if (!lit) begin
               count_in = count_up;
               if (count_up >= off_need) begin
                  phase_in = PH_OFF;
                  count_in = '0;
               end
            end else begin
               phase_in = PH_ON;
               count_in = '0;
            end
         end
         default: begin
            phase_in = PH_OFF;
            count_in = '0;
         end
      endcase
   end

   // The changed flag compares against the phase after the timeout check,
   // so a forced drop to off is not reported by itself.
   assign flags.stable_valid = (phase_in == PH_ON) || (phase_in == PH_CAND_OFF);
   assign flags.stable_lit   = (phase_in == PH_ON);
   assign flags.changed      = (phase_in != prev);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OFF;
         count_ff     <= '0;
         last_seen_ff <= '0;
         seen_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         last_seen_ff <= last_seen_in;
         seen_ff      <= seen_in;
      end
   end

endmodule

`default_nettype wire

// File: design/mdb_merge.sv
// ----------------------------------------------------------------------------
// mdb_merge
// Gathers the per-slot flags into the result masks and counts the slots
// that are stably lit, saturating the count at its field's maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module mdb_merge #(
   parameter int SLOT_COUNT = 5
) (
   input  wire mdb_pkg::slot_flags_type flags [SLOT_COUNT],
   output mdb_pkg::result_type          result
);
   import mdb_pkg::*;

   localparam int SUM_W = $clog2(SLOT_COUNT + 1);
   localparam int MAPPED = (SLOT_COUNT < MASK_W) ? SLOT_COUNT : MASK_W;

   logic [SUM_W-1:0]   lit_sum;
   logic [TOTAL_W-1:0] lit_sat;

   always_comb begin
      result.stable_valid_bits = '0;
      result.stable_lit_bits   = '0;
      result.changed_bits      = '0;
      for (int i = 0; i < MAPPED; i++) begin
         result.stable_valid_bits[i] = flags[i].stable_valid;
         result.stable_lit_bits[i]   = flags[i].stable_lit;
         result.changed_bits[i]      = flags[i].changed;
      end
      result.lit_total = lit_sat;
   end

   always_comb begin
      lit_sum = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         lit_sum = lit_sum + SUM_W'(flags[i].stable_lit);
      end
   end

   // Slots beyond the mask width still count toward the total.
   always_comb begin
      if (32'(lit_sum) > 32'((1 << TOTAL_W) - 1)) begin
         lit_sat = '1;
      end else begin
         lit_sat = TOTAL_W'(lit_sum);
      end
   end

endmodule

`default_nettype wire

// File: design/multi_slot_debounce_fsm.sv
// ----------------------------------------------------------------------------
// multi_slot_debounce_fsm
// Per-slot debouncer with a missing timeout. Each request beat is one frame;
// every slot lane updates in parallel and a merge stage builds the masks.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | req_valid/req_stall  | frame time, detected, lit bits
//   rsp     | out       | rsp_valid/rsp_stall  | valid, lit, changed masks, total
//   csr     | in        | csr_write_enable     | csr_index, csr_write_data
//
// One frame per cycle unless req_stall is high; a frame's response is registered.
// The lane timeout subtract/compare sets the critical path.
// A second output register absorbs one beat while rsp_stall is high, so
// req_stall rises only after two responses are waiting.
// Reset is synchronous: all slots return to off, counters and timestamps to
// zero, and the registers to 3, 4 and 120000.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_slot_debounce_fsm #(
   parameter int SLOT_COUNT = 5
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [mdb_pkg::TIME_W-1:0]    req_frame_time_us,
   input  wire logic [mdb_pkg::MASK_W-1:0]    req_detected_bits,
   input  wire logic [mdb_pkg::MASK_W-1:0]    req_lit_bits,

   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [mdb_pkg::MASK_W-1:0]    rsp_stable_valid_bits,
   output      logic [mdb_pkg::MASK_W-1:0]    rsp_stable_lit_bits,
   output      logic [mdb_pkg::MASK_W-1:0]    rsp_changed_bits,
   output      logic [mdb_pkg::TOTAL_W-1:0]   rsp_lit_total,

   input  wire logic                          csr_write_enable,
   input  wire logic [mdb_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mdb_pkg::TIME_W-1:0]    csr_write_data
);
   import mdb_pkg::*;

   // Configuration registers.
   logic [COUNT_W-1:0] frames_on_ff;
   logic [COUNT_W-1:0] frames_off_ff;
   logic [TIME_W-1:0]  timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_on_ff  <= DEFAULT_ON;
         frames_off_ff <= DEFAULT_OFF;
         timeout_ff    <= DEFAULT_TIMEOUT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAMES_ON:  frames_on_ff  <= csr_write_data[COUNT_W-1:0];
            CSR_FRAMES_OFF: frames_off_ff <= csr_write_data[COUNT_W-1:0];
            CSR_TIMEOUT:    timeout_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // A zero in a register selects its default.
   logic [COUNT_W-1:0] on_need;
   logic [COUNT_W-1:0] off_need;
   logic [TIME_W-1:0]  timeout;

   assign on_need  = (frames_on_ff  == '0) ? DEFAULT_ON      : frames_on_ff;
   assign off_need = (frames_off_ff == '0) ? DEFAULT_OFF     : frames_off_ff;
   assign timeout  = (timeout_ff    == '0) ? DEFAULT_TIMEOUT : timeout_ff;

   // Output register plus skid register.
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       accept;
   logic       take;
   result_type merged;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;

   slot_flags_type flags [SLOT_COUNT];

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_lane
      logic det_bit;
      logic lit_bit;
      if (g < MASK_W) begin : g_mapped
         assign det_bit = req_detected_bits[g];
         assign lit_bit = req_lit_bits[g];
      end else begin : g_unmapped
         assign det_bit = 1'b0;
         assign lit_bit = 1'b0;
      end

      mdb_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .accept   (accept),
         .now      (req_frame_time_us),
         .detected (det_bit),
         .lit_raw  (lit_bit),
         .on_need  (on_need),
         .off_need (off_need),
         .timeout  (timeout),
         .flags    (flags[g])
      );
   end

   mdb_merge #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_merge (
      .flags  (flags),
      .result (merged)
   );

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_in       = merged;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = merged;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_stable_valid_bits = out_ff.stable_valid_bits;
   assign rsp_stable_lit_bits   = out_ff.stable_lit_bits;
   assign rsp_changed_bits      = out_ff.changed_bits;
   assign rsp_lit_total         = out_ff.lit_total;

endmodule

`default_nettype wire

// File: tb/sv/multi_slot_debounce_fsm_tb.sv
// ----------------------------------------------------------------------------
// multi_slot_debounce_fsm_tb
// Self-checking bench for the multi-slot debouncer. A driver feeds frame beats
// from a queue, a predictor tracks every slot's debounce phase, counter and
// last-seen time, and a monitor checks each response beat against the oldest
// prediction. Thresholds and timeout are rewritten between phases while the
// block is idle, and both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_slot_debounce_fsm_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mdb_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum logic [1:0] {
      PHASE_OFF       = 2'd0,
      PHASE_ARMING    = 2'd1,
      PHASE_ON        = 2'd2,
      PHASE_RELEASING = 2'd3
   } slot_phase_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_us;
      logic [MASK_W-1:0] detected;
      logic [MASK_W-1:0] lit;
   } frame_item_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [TIME_W-1:0]    req_frame_time_us = '0;
   logic [MASK_W-1:0]    req_detected_bits = '0;
   logic [MASK_W-1:0]    req_lit_bits = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [MASK_W-1:0]    rsp_stable_valid_bits;
   logic [MASK_W-1:0]    rsp_stable_lit_bits;
   logic [MASK_W-1:0]    rsp_changed_bits;
   logic [TOTAL_W-1:0]   rsp_lit_total;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0]    csr_write_data = '0;

   // Predictor copy of the registers and the per-slot state.
   logic [COUNT_W-1:0]   cfg_frames_on  = DEFAULT_ON;
   logic [COUNT_W-1:0]   cfg_frames_off = DEFAULT_OFF;
   logic [TIME_W-1:0]    cfg_timeout_us = DEFAULT_TIMEOUT;
   slot_phase_type       slot_state [MASK_W];
   logic [COUNT_W-1:0]   slot_run_count [MASK_W];
   logic [TIME_W-1:0]    slot_seen_at [MASK_W];
   logic                 slot_seen_ever [MASK_W];

   frame_item_type       pending_frames [$];
   result_type           expected_results [$];
   result_type           rsp_seen;
   result_type           rsp_want;

   // Stimulus shaping.
   logic [TIME_W-1:0]    frame_clock;
   logic                 want_lit [MASK_W];
   int                   run_left [MASK_W];
   int                   noise_pct = 4;
   logic                 sender_gaps_on = 1'b1;
   logic                 receiver_stalls_on = 1'b1;
   int                   req_gap_left = 0;
   int                   rsp_stall_left = 0;
   logic                 req_beat_taken = 1'b0;
   int                   error_count = 0;

   multi_slot_debounce_fsm dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_frame_time_us     (req_frame_time_us),
      .req_detected_bits     (req_detected_bits),
      .req_lit_bits          (req_lit_bits),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_stable_valid_bits (rsp_stable_valid_bits),
      .rsp_stable_lit_bits   (rsp_stable_lit_bits),
      .rsp_changed_bits      (rsp_changed_bits),
      .rsp_lit_total         (rsp_lit_total),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always #1 clock = ~clock;

   initial begin
      for (int s = 0; s < MASK_W; s++) begin
         slot_state[s]     = PHASE_OFF;
         slot_run_count[s] = '0;
         slot_seen_at[s]   = '0;
         slot_seen_ever[s] = 1'b0;
         want_lit[s]       = 1'b0;
         run_left[s]       = 0;
      end
   end

   // Advances every slot by one frame and returns the response it must give.
   function automatic result_type debounce_frame(input logic [TIME_W-1:0] now,
                                                 input logic [MASK_W-1:0] det_bits,
                                                 input logic [MASK_W-1:0] lit_bits);
      result_type         res;
      logic [COUNT_W-1:0] need_on;
      logic [COUNT_W-1:0] need_off;
      logic [TIME_W-1:0]  limit_us;
      logic [TIME_W-1:0]  elapsed;
      slot_phase_type     prev;
      slot_phase_type     nxt;
      logic               det;
      logic               lit;
      res      = '0;
      need_on  = (cfg_frames_on == '0) ? DEFAULT_ON : cfg_frames_on;
      need_off = (cfg_frames_off == '0) ? DEFAULT_OFF : cfg_frames_off;
      limit_us = (cfg_timeout_us == '0) ? DEFAULT_TIMEOUT : cfg_timeout_us;
      for (int s = 0; s < MASK_W; s++) begin
         det     = det_bits[s];
         lit     = det & lit_bits[s];
         elapsed = now - slot_seen_at[s];
         // The timeout is checked against the previous sighting, before this
         // frame's detection refreshes it.
         if (slot_state[s] != PHASE_OFF && slot_seen_ever[s] && elapsed > limit_us) begin
            slot_state[s]     = PHASE_OFF;
            slot_run_count[s] = '0;
         end
         prev = slot_state[s];
         if (det) begin
            slot_seen_at[s]   = now;
            slot_seen_ever[s] = 1'b1;
         end
         nxt = prev;
         case (prev)
            PHASE_OFF: begin
               if (lit) begin
                  nxt               = PHASE_ARMING;
                  slot_run_count[s] = 8'd1;
               end
            end
            PHASE_ARMING: begin
               if (lit) begin
                  slot_run_count[s] = (slot_run_count[s] == 8'hFF) ? 8'hFF
                                      : slot_run_count[s] + 8'd1;
                  if (slot_run_count[s] >= need_on)
                     nxt = PHASE_ON;
               end else begin
                  nxt               = PHASE_OFF;
                  slot_run_count[s] = '0;
               end
            end
            PHASE_ON: begin
               if (!lit) begin
                  nxt               = PHASE_RELEASING;
                  slot_run_count[s] = 8'd1;
               end
            end
            default: begin
               if (!lit) begin
                  slot_run_count[s] = (slot_run_count[s] == 8'hFF) ? 8'hFF
                                      : slot_run_count[s] + 8'd1;
                  if (slot_run_count[s] >= need_off) begin
                     nxt               = PHASE_OFF;
                     slot_run_count[s] = '0;
                  end
               end else begin
                  nxt               = PHASE_ON;
                  slot_run_count[s] = '0;
               end
            end
         endcase
         slot_state[s] = nxt;
         res.stable_valid_bits[s] = (nxt == PHASE_ON) || (nxt == PHASE_RELEASING);
         res.stable_lit_bits[s]   = (nxt == PHASE_ON);
         res.changed_bits[s]      = (nxt != prev);
         if (nxt == PHASE_ON)
            res.lit_total = res.lit_total + 3'd1;
      end
      return res;
   endfunction

   // Mostly short idle runs, now and then a long one.
   function automatic int draw_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Driver: presents queued frames at the falling edge.
   always @(negedge clock) begin
      if (!req_valid || req_beat_taken) begin
         if (req_gap_left != 0) begin
            req_gap_left = req_gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_frames.size() != 0) begin
            req_valid         <= 1'b1;
            req_frame_time_us <= pending_frames[0].time_us;
            req_detected_bits <= pending_frames[0].detected;
            req_lit_bits      <= pending_frames[0].lit;
            void'(pending_frames.pop_front());
            req_gap_left = sender_gaps_on ? draw_idle() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Each accepted frame beat is run through the predictor right away.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_results.push_back(debounce_frame(req_frame_time_us, req_detected_bits,
                                                   req_lit_bits));
         req_beat_taken = 1'b1;
      end else begin
         req_beat_taken = 1'b0;
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left = rsp_stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (receiver_stalls_on && $urandom_range(0, 3) == 0)
            rsp_stall_left = draw_idle();
      end
   end

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t ns: %s mismatch, expected 'h%0h, actual 'h%0h", $time, field, want, got);
      error_count++;
   endtask

   // Monitor: checks each response beat against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen = {rsp_stable_valid_bits, rsp_stable_lit_bits, rsp_changed_bits,
                     rsp_lit_total};
         if (expected_results.size() == 0) begin
            $display("%0t ns: unexpected response beat, expected none, actual %p",
                     $time, rsp_seen);
            error_count++;
         end else begin
            rsp_want = expected_results.pop_front();
            if (rsp_seen.stable_valid_bits !== rsp_want.stable_valid_bits)
               report_mismatch("stable_valid_bits", rsp_want.stable_valid_bits,
                               rsp_seen.stable_valid_bits);
            if (rsp_seen.stable_lit_bits !== rsp_want.stable_lit_bits)
               report_mismatch("stable_lit_bits", rsp_want.stable_lit_bits,
                               rsp_seen.stable_lit_bits);
            if (rsp_seen.changed_bits !== rsp_want.changed_bits)
               report_mismatch("changed_bits", rsp_want.changed_bits,
                               rsp_seen.changed_bits);
            if (rsp_seen.lit_total !== rsp_want.lit_total)
               report_mismatch("lit_total", rsp_want.lit_total, rsp_seen.lit_total);
         end
      end
   end

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [TIME_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_FRAMES_ON:  cfg_frames_on  = data[COUNT_W-1:0];
         CSR_FRAMES_OFF: cfg_frames_off = data[COUNT_W-1:0];
         CSR_TIMEOUT:    cfg_timeout_us = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_frames.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_frame(input logic [TIME_W-1:0] step, input logic [MASK_W-1:0] det,
                             input logic [MASK_W-1:0] lit);
      frame_item_type f;
      frame_clock = frame_clock + step;
      f.time_us   = frame_clock;
      f.detected  = det;
      f.lit       = lit;
      pending_frames.push_back(f);
   endtask

   // Per-slot runs of lit and unlit frames long enough to walk the debouncer
   // through all phases, with glitches, dropouts and time jumps mixed in.
   task automatic gen_frames(input int count);
      int                need_on;
      int                need_off;
      logic [TIME_W-1:0] limit_us;
      logic [TIME_W-1:0] step;
      logic [MASK_W-1:0] det;
      logic [MASK_W-1:0] lit;
      int                r;
      need_on  = (cfg_frames_on == '0) ? DEFAULT_ON : cfg_frames_on;
      need_off = (cfg_frames_off == '0) ? DEFAULT_OFF : cfg_frames_off;
      limit_us = (cfg_timeout_us == '0) ? DEFAULT_TIMEOUT : cfg_timeout_us;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 70)
            step = $urandom_range(0, limit_us >> 3);
         else if (r < 88)
            step = $urandom_range(0, limit_us);
         else if (r < 97)
            step = limit_us + $urandom_range(0, 2);
         else
            step = $urandom();
         if ($urandom_range(0, 99) < noise_pct) begin
            det = $urandom();
            lit = $urandom();
         end else begin
            for (int s = 0; s < MASK_W; s++) begin
               if (run_left[s] == 0) begin
                  want_lit[s] = $urandom_range(0, 1);
                  run_left[s] = $urandom_range(1, need_on + need_off + 4);
               end
               run_left[s] = run_left[s] - 1;
               det[s] = ($urandom_range(0, 99) >= noise_pct);
               lit[s] = want_lit[s] ^ ($urandom_range(0, 99) < noise_pct);
            end
         end
         push_frame(step, det, lit);
      end
   endtask

   // Each phase starts only once every earlier frame has been answered.
   task automatic run_phase(input logic [COUNT_W-1:0] rise_count,
                            input logic [COUNT_W-1:0] fall_count,
                            input logic [TIME_W-1:0] timeout_us, input int count,
                            input logic idle_on, input int noise);
      logic [TIME_W-1:0] junk;
      wait_drained();
      junk = $urandom();
      write_register(CSR_SPARE, $urandom());
      write_register(CSR_FRAMES_ON, {junk[31:8], rise_count});
      junk = $urandom();
      write_register(CSR_FRAMES_OFF, {junk[31:8], fall_count});
      write_register(CSR_TIMEOUT, timeout_us);
      sender_gaps_on     = idle_on;
      receiver_stalls_on = idle_on;
      noise_pct          = noise;
      gen_frames(count);
   endtask

   initial begin
      logic [COUNT_W-1:0] rise_count;
      logic [COUNT_W-1:0] fall_count;
      logic [TIME_W-1:0]  timeout_us;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames at the reset settings, starting just below the wrap.
      frame_clock = 32'hFFFF_F000;
      push_frame(0, 5'h00, 5'h1F);          // lit but not detected
      repeat (3) push_frame(10, 5'h1F, 5'h1F);
      push_frame(10, 5'h1F, 5'h00);
      push_frame(10, 5'h1F, 5'h1F);          // back to on from candidate off
      repeat (4) push_frame(10, 5'h1F, 5'h00);
      repeat (3) push_frame(32'h1000, 5'h1F, 5'h1F);
      push_frame(DEFAULT_TIMEOUT, 5'h00, 5'h00);   // exactly at the timeout
      push_frame(1, 5'h00, 5'h00);                 // one past it: forced off
      repeat (3) push_frame(10, 5'h1F, 5'h15);
      push_frame(10, 5'h0A, 5'h1F);
      push_frame(32'hFFFF_FFFF, 5'h1F, 5'h0A);     // time steps back by one
      repeat (2) push_frame(0, 5'h1F, 5'h0A);

      run_phase(8'd0, 8'd0, 32'd0, 300, 1'b0, 4);
      run_phase(8'd1, 8'd1, 32'd1, 300, 1'b1, 4);
      run_phase(8'd255, 8'd255, 32'hFFFF_FFFF, 400, 1'b1, 0);
      for (int p = 0; p < 4; p++) begin
         rise_count = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
         fall_count = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
         case ($urandom_range(0, 2))
            0:       timeout_us = '0;
            1:       timeout_us = $urandom_range(1, 2000);
            default: timeout_us = $urandom_range(2000, 200000);
         endcase
         run_phase(rise_count, fall_count, timeout_us, 200, ($urandom_range(0, 3) != 0), 4);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("PASS multi_slot_debounce_fsm");
      else
         $display("FAIL multi_slot_debounce_fsm");
      $finish;
   end

   initial begin
      #3000000;
      $display("FAIL multi_slot_debounce_fsm");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
design/mdb_pkg.sv
design/mdb_lane.sv
design/mdb_merge.sv
design/multi_slot_debounce_fsm.sv
tb/sv/multi_slot_debounce_fsm_tb.sv
